FILE: sv/vcp_pkg.sv
`default_nettype none

package vcp_pkg;

    localparam logic [7:0] EQ_CHAR  = 8'h3D;
    localparam logic [7:0] LOWER_A  = 8'h61;
    localparam logic [7:0] LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [2:0] {
        ROLE_LEN    = 3'd0,
        ROLE_VENDOR = 3'd1,
        ROLE_COUNT  = 3'd2,
        ROLE_KEY    = 3'd3,
        ROLE_SEP    = 3'd4,
        ROLE_VALUE  = 3'd5,
        ROLE_TRAIL  = 3'd6
    } role_t;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_TRUNC = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        role_t       role;
        logic [31:0] comment_number;
        logic        field_end;
        status_t     status;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/vcp_core.sv
`default_nettype none

module vcp_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             take,
    input  wire logic [7:0]       byte_in,
    input  wire logic             last_byte,
    output vcp_pkg::result_t      res
);
    import vcp_pkg::*;

    typedef enum logic [2:0] {
        PH_VLEN   = 3'd0,
        PH_VENDOR = 3'd1,
        PH_COUNT  = 3'd2,
        PH_CLEN   = 3'd3,
        PH_BODY   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] comments_reg, comments_next;
    logic [31:0] cur_reg, cur_next;
    logic        sep_reg, sep_next;

    logic        hdr_done;
    logic [31:0] hdr_word;
    logic [31:0] acc_base;
    logic        field_last;
    logic        comment_last;

    assign hdr_done     = (idx_reg == 2'd3);
    assign hdr_word     = {byte_in, acc_reg[23:0]};
    assign acc_base     = (idx_reg == 2'd0) ? 32'd0 : acc_reg;
    assign field_last   = (left_reg == 32'd1);
    assign comment_last = (comments_reg == 32'd1);

    always_comb begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        acc_next      = acc_reg;
        left_next     = left_reg;
        comments_next = comments_reg;
        cur_next      = cur_reg;
        sep_next      = sep_reg;

        res.byte_out       = byte_in;
        res.role           = ROLE_TRAIL;
        res.comment_number = 32'd0;
        res.field_end      = 1'b0;
        res.status         = ST_BUSY;

        unique case (phase_reg)
            PH_VLEN: begin
                res.role = ROLE_LEN;
                idx_next = idx_reg + 2'd1;
                acc_next = acc_base | ({24'd0, byte_in} << {idx_reg, 3'b000});
                if (hdr_done) begin
                    if (hdr_word == 32'd0) begin
                        res.field_end = 1'b1;
                        phase_next    = PH_COUNT;
                    end else begin
                        left_next  = hdr_word;
                        phase_next = PH_VENDOR;
                    end
                end
            end
            PH_VENDOR: begin
                res.role  = ROLE_VENDOR;
                left_next = left_reg - 32'd1;
                if (field_last) begin
                    res.field_end = 1'b1;
                    phase_next    = PH_COUNT;
                end
            end
            PH_COUNT: begin
                res.role = ROLE_COUNT;
                idx_next = idx_reg + 2'd1;
                acc_next = acc_base | ({24'd0, byte_in} << {idx_reg, 3'b000});
                if (hdr_done) begin
                    comments_next = hdr_word;
                    cur_next      = 32'd0;
                    sep_next      = 1'b0;
                    if (hdr_word == 32'd0) begin
                        phase_next = PH_DONE;
                        res.status = ST_DONE;
                    end else begin
                        phase_next = PH_CLEN;
                    end
                end
            end
            PH_CLEN: begin
                res.role           = ROLE_LEN;
                res.comment_number = cur_reg;
                idx_next = idx_reg + 2'd1;
                acc_next = acc_base | ({24'd0, byte_in} << {idx_reg, 3'b000});
                if (hdr_done) begin
                    if (hdr_word == 32'd0) begin
                        res.field_end = 1'b1;
                        comments_next = comments_reg - 32'd1;
                        cur_next      = cur_reg + 32'd1;
                        sep_next      = 1'b0;
                        if (comment_last) begin
                            phase_next = PH_DONE;
                            res.status = ST_DONE;
                        end
                    end else begin
                        left_next  = hdr_word;
                        sep_next   = 1'b0;
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                res.comment_number = cur_reg;
                if (!sep_reg && byte_in == EQ_CHAR) begin
                    res.role = ROLE_SEP;
                    sep_next = 1'b1;
                end else if (!sep_reg) begin
                    res.role = ROLE_KEY;
                    if (byte_in >= LOWER_A && byte_in <= LOWER_Z) begin
                        res.byte_out = byte_in - CASE_BIT;
                    end
                end else begin
                    res.role = ROLE_VALUE;
                end
                left_next = left_reg - 32'd1;
                if (field_last) begin
                    res.field_end = 1'b1;
                    comments_next = comments_reg - 32'd1;
                    cur_next      = cur_reg + 32'd1;
                    sep_next      = 1'b0;
                    if (comment_last) begin
                        phase_next = PH_DONE;
                        res.status = ST_DONE;
                    end else begin
                        phase_next = PH_CLEN;
                    end
                end
            end
            default: begin
                res.role   = ROLE_TRAIL;
                res.status = ST_DONE;
            end
        endcase

        if (last_byte && res.status != ST_DONE) begin
            res.status = ST_TRUNC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && last_byte)) begin
            phase_reg    <= PH_VLEN;
            idx_reg      <= 2'd0;
            acc_reg      <= 32'd0;
            left_reg     <= 32'd0;
            comments_reg <= 32'd0;
            cur_reg      <= 32'd0;
            sep_reg      <= 1'b0;
        end else if (take) begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            acc_reg      <= acc_next;
            left_reg     <= left_next;
            comments_reg <= comments_next;
            cur_reg      <= cur_next;
            sep_reg      <= sep_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/vorbis_comment_parser_unit.sv
// A result is registered and appears in the cycle after its byte transfer.
// Throughput: one byte per cycle unless the output stalls; the parse state
//   update (32-bit decrement and compare) runs in the cycle the byte is taken.
// A stalled result holds in the output register; input is taken when it drains.
// Reset (aresetn low, synchronous) returns the parser to the vendor length
//   header and empties the output register; state also resets after a last byte.
`default_nettype none

module vorbis_comment_parser_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_byte_in,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_byte_out,
    output logic [2:0]       m_role,
    output logic [31:0]      m_comment_number,
    output logic             m_field_end,
    output logic [1:0]       m_status
);
    import vcp_pkg::*;

    logic    take;
    logic    m_valid_reg;
    result_t res;
    result_t res_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;

    vcp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .byte_in   (s_byte_in),
        .last_byte (s_last_byte),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_byte_out       = res_reg.byte_out;
    assign m_role           = res_reg.role;
    assign m_comment_number = res_reg.comment_number;
    assign m_field_end      = res_reg.field_end;
    assign m_status         = res_reg.status;

`ifndef SYNTHESIS
    a_trail_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && res_reg.role == ROLE_TRAIL |-> res_reg.status == ST_DONE)
        else $error("trailing byte without complete status");

    a_sep_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && res_reg.role == ROLE_SEP |-> res_reg.byte_out == EQ_CHAR)
        else $error("separator role on non-separator byte");

    a_outer_num: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (res_reg.role == ROLE_VENDOR || res_reg.role == ROLE_COUNT
            || res_reg.role == ROLE_TRAIL) |-> res_reg.comment_number == 32'd0)
        else $error("nonzero comment number outside comments");

    a_take_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> m_valid)
        else $error("transfer taken but no result presented");
`endif

endmodule

`default_nettype wire

FILE: verif/vcp_checker.sv
`timescale 1ns / 100ps

module vcp_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_last_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_byte_out,
    input  logic [2:0]  m_role,
    input  logic [31:0] m_comment_number,
    input  logic        m_field_end,
    input  logic [1:0]  m_status,
    output int          errors,
    output int          outstanding
);
    import vcp_pkg::*;

    typedef enum logic [2:0] {
        PH_VLEN,
        PH_VENDOR,
        PH_COUNT,
        PH_CLEN,
        PH_BODY,
        PH_DONE
    } parse_phase_t;

    parse_phase_t phase;
    logic [1:0]   hdr_idx;
    logic [31:0]  len_acc;
    logic [31:0]  field_left;
    logic [31:0]  comments_left;
    logic [31:0]  cur_comment;
    logic         seen_sep;

    result_t expected_q[$];

    function automatic void reset_parser();
        phase         = PH_VLEN;
        hdr_idx       = '0;
        len_acc       = '0;
        field_left    = '0;
        comments_left = '0;
        cur_comment   = '0;
        seen_sep      = 1'b0;
    endfunction

    // little-endian 32-bit header, one byte at a time
    function automatic bit take_hdr(input logic [7:0] b);
        if (hdr_idx == 2'd0) begin
            len_acc = '0;
        end
        len_acc[hdr_idx*8 +: 8] = b;
        if (hdr_idx == 2'd3) begin
            hdr_idx = '0;
            return 1'b1;
        end
        hdr_idx = hdr_idx + 2'd1;
        return 1'b0;
    endfunction

    function automatic bit close_comment();
        comments_left = comments_left - 32'd1;
        cur_comment   = cur_comment + 32'd1;
        seen_sep      = 1'b0;
        if (comments_left == '0) begin
            phase = PH_DONE;
            return 1'b1;
        end
        phase = PH_CLEN;
        return 1'b0;
    endfunction

    function automatic result_t parse_byte(input logic [7:0] b, input logic last);
        result_t r;
        r.byte_out       = b;
        r.role           = ROLE_TRAIL;
        r.comment_number = '0;
        r.field_end      = 1'b0;
        r.status         = ST_BUSY;
        case (phase)
            PH_VLEN: begin
                r.role = ROLE_LEN;
                if (take_hdr(b)) begin
                    if (len_acc == '0) begin
                        r.field_end = 1'b1;
                        phase       = PH_COUNT;
                    end else begin
                        field_left = len_acc;
                        phase      = PH_VENDOR;
                    end
                end
            end
            PH_VENDOR: begin
                r.role     = ROLE_VENDOR;
                field_left = field_left - 32'd1;
                if (field_left == '0) begin
                    r.field_end = 1'b1;
                    phase       = PH_COUNT;
                end
            end
            PH_COUNT: begin
                r.role = ROLE_COUNT;
                if (take_hdr(b)) begin
                    comments_left = len_acc;
                    cur_comment   = '0;
                    seen_sep      = 1'b0;
                    if (comments_left == '0) begin
                        phase    = PH_DONE;
                        r.status = ST_DONE;
                    end else begin
                        phase = PH_CLEN;
                    end
                end
            end
            PH_CLEN: begin
                r.role           = ROLE_LEN;
                r.comment_number = cur_comment;
                if (take_hdr(b)) begin
                    if (len_acc == '0) begin
                        r.field_end = 1'b1;
                        if (close_comment()) begin
                            r.status = ST_DONE;
                        end
                    end else begin
                        field_left = len_acc;
                        seen_sep   = 1'b0;
                        phase      = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                r.comment_number = cur_comment;
                if (!seen_sep && b == EQ_CHAR) begin
                    r.role   = ROLE_SEP;
                    seen_sep = 1'b1;
                end else if (!seen_sep) begin
                    r.role = ROLE_KEY;
                    if (b >= LOWER_A && b <= LOWER_Z) begin
                        r.byte_out = b - CASE_BIT;
                    end
                end else begin
                    r.role = ROLE_VALUE;
                end
                field_left = field_left - 32'd1;
                if (field_left == '0) begin
                    r.field_end = 1'b1;
                    if (close_comment()) begin
                        r.status = ST_DONE;
                    end
                end
            end
            default: begin
                r.role   = ROLE_TRAIL;
                r.status = ST_DONE;
            end
        endcase
        if (last) begin
            if (r.status != ST_DONE) begin
                r.status = ST_TRUNC;
            end
            reset_parser();
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors = errors + 1;
        end
    endtask

    initial begin
        errors      = 0;
        outstanding = 0;
        reset_parser();
    end

    always @(posedge aclk) begin : monitor
        result_t want;
        if (!aresetn) begin
            expected_q.delete();
            reset_parser();
            outstanding = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, got byte %0h role %0d",
                             $time, m_byte_out, m_role);
                    errors = errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    check_field("byte_out", 32'(want.byte_out), 32'(m_byte_out));
                    check_field("role", 32'(want.role), 32'(m_role));
                    check_field("comment_number", want.comment_number, m_comment_number);
                    check_field("field_end", 32'(want.field_end), 32'(m_field_end));
                    check_field("status", 32'(want.status), 32'(m_status));
                end
            end
            if (s_valid && s_ready) begin
                expected_q.push_back(parse_byte(s_byte_in, s_last_byte));
            end
            outstanding = expected_q.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import vcp_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_BYTES  = 417;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_in   = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_byte_out;
    logic [2:0]  m_role;
    logic [31:0] m_comment_number;
    logic        m_field_end;
    logic [1:0]  m_status;
    int          errors;
    int          outstanding;

    int          src_idle    = 0;
    int          sink_idle   = 0;
    int          bytes_sent  = 0;
    int          packets     = 0;
    int          cut_packets = 0;
    int          stall_cycles = 0;
    logic [7:0]  pkt_q[$];

    vorbis_comment_parser_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_in        (s_byte_in),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_out       (m_byte_out),
        .m_role           (m_role),
        .m_comment_number (m_comment_number),
        .m_field_end      (m_field_end),
        .m_status         (m_status)
    );

    vcp_checker u_chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_in        (s_byte_in),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_out       (m_byte_out),
        .m_role           (m_role),
        .m_comment_number (m_comment_number),
        .m_field_end      (m_field_end),
        .m_status         (m_status),
        .errors           (errors),
        .outstanding      (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_idle);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        logic rdy;
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_byte_in   <= b;
        s_last_byte <= last;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
        bytes_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_q.size(); i++) begin
            send_byte(pkt_q[i], i == pkt_q.size() - 1);
        end
        packets++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) begin
            @(negedge aclk);
        end
        @(posedge aclk);
    endtask

    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) begin
            pkt_q.push_back(w[i*8 +: 8]);
        end
    endfunction

    function automatic logic [7:0] body_char(input bit no_sep);
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range(LOWER_A, LOWER_Z));
            1: return 8'($urandom_range(8'h41, 8'h5A));
            2: return 8'($urandom_range(0, 255));
            3: return no_sep ? LOWER_Z : EQ_CHAR;
            default: return $urandom_range(0, 1) ? LOWER_A - 8'd1 : LOWER_Z + 8'd1;
        endcase
    endfunction

    // mostly well-formed packets; some cut short, some pure noise
    function automatic void build_packet();
        int kind;
        int vlen;
        int ncom;
        int clen;
        int cut;
        bit no_sep;
        pkt_q.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 12)) pkt_q.push_back(8'($urandom_range(0, 255)));
            cut_packets++;
            return;
        end
        vlen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
        put_word(vlen);
        repeat (vlen) pkt_q.push_back(8'($urandom_range(0, 255)));
        ncom = $urandom_range(0, 4);
        put_word(ncom);
        repeat (ncom) begin
            clen = $urandom_range(0, 10);
            no_sep = ($urandom_range(0, 4) == 0);
            put_word(clen);
            repeat (clen) pkt_q.push_back(body_char(no_sep));
        end
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) pkt_q.push_back(8'($urandom_range(0, 255)));
        end
        if (kind <= 2) begin
            cut = $urandom_range(1, pkt_q.size() - 1);
            while (pkt_q.size() > cut) void'(pkt_q.pop_back());
            cut_packets++;
        end
    endfunction

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty vendor, zero comments
        pkt_q.delete();
        put_word(32'd0);
        put_word(32'd0);
        send_packet();

        // one vendor byte, empty comment, key/separator/value, trailing byte
        pkt_q.delete();
        put_word(32'd1);
        pkt_q.push_back(8'h76);
        put_word(32'd2);
        put_word(32'd0);
        put_word(32'd3);
        pkt_q.push_back(LOWER_A);
        pkt_q.push_back(EQ_CHAR);
        pkt_q.push_back(EQ_CHAR);
        pkt_q.push_back(8'hFF);
        send_packet();

        // cut short inside the vendor length
        pkt_q.delete();
        pkt_q.push_back(8'h7B);
        pkt_q.push_back(8'h00);
        send_packet();
        cut_packets++;
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            int target;
            case (ph)
                0: begin src_idle = 37; sink_idle = 53; end
                1: begin src_idle = 53; sink_idle = 37; end
                default: begin src_idle = 0; sink_idle = 0; end
            endcase
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                build_packet();
                send_packet();
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        $display("Covered %0d bytes in %0d packets, %0d of them truncated or noise,",
                 bytes_sent, packets, cut_packets);
        $display("under source/sink idle mixes 37/53, 53/37 and none.");
        if (errors == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
